// ===== design/cmma_pkg.sv =====
package cmma_pkg;

  localparam int DIM       = 3;
  localparam int ELEM_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int DEPTH  = DIM * DIM;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DIM);
  localparam int PROD_W = 2 * ELEM_BITS - FRAC_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam int STEP_W = 4;

  localparam logic [ELEM_BITS-1:0] ELEM_MAX = {1'b0, {(ELEM_BITS - 1){1'b1}}};
  localparam logic [ELEM_BITS-1:0] ELEM_MIN = {1'b1, {(ELEM_BITS - 1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_WR_A    = 2'd0,
    FUNC_WR_B    = 2'd1,
    FUNC_WR_C    = 2'd2,
    FUNC_COMPUTE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ACC_NONE   = 3'd0,
    ACC_LOAD   = 3'd1,
    ACC_ADD_RE = 3'd2,
    ACC_SUB_RE = 3'd3,
    ACC_ADD_IM = 3'd4
  } acc_op_t;

  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_START = 3'd2,
    COND_K_MORE   = 3'd3,
    COND_IJ_MORE  = 3'd4
  } cond_t;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] re;
    logic signed [ELEM_BITS-1:0] im;
  } cval_t;

  typedef struct packed {
    logic              idle;
    logic              a_im;
    logic              b_im;
    logic              mul;
    acc_op_t           acc;
    logic              wb;
    logic              k_adv;
    logic              ij_adv;
    logic              emit;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic k_last;
    logic ij_last;
    logic out_free;
  } stat_t;

  function automatic logic [ELEM_BITS-1:0] sat_elem(input logic [ACC_W-1:0] v);
    logic ovf;
    begin
      ovf = (v[ACC_W-1:ELEM_BITS-1] != {(ACC_W - ELEM_BITS + 1){v[ACC_W-1]}});
      if (ovf) begin
        return v[ACC_W-1] ? ELEM_MIN : ELEM_MAX;
      end
      return v[ELEM_BITS-1:0];
    end
  endfunction

endpackage

// ===== design/cmma_sequencer.sv =====
module cmma_sequencer import cmma_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output ctl_t  ctl
);

  localparam logic [STEP_W-1:0] ST_IDLE   = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_FETCH  = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_MUL_RR = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_MUL_II = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_MUL_IR = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_MUL_RI = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_ADD_RI = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_WB     = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_NEXT   = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_EMIT   = STEP_W'(9);
  localparam logic [STEP_W-1:0] ST_DONE   = STEP_W'(10);

  function automatic ctl_t ucode(input logic [STEP_W-1:0] s);
    ctl_t w;
    begin
      w = '0;
      w.acc  = ACC_NONE;
      w.cond = COND_NEXT;
      case (s)
        ST_IDLE: begin
          w.idle   = 1'b1;
          w.cond   = COND_NO_START;
          w.target = ST_IDLE;
        end
        ST_FETCH: begin
          w.acc = ACC_LOAD;
        end
        ST_MUL_RR: begin
          w.mul = 1'b1;
        end
        ST_MUL_II: begin
          w.mul  = 1'b1;
          w.a_im = 1'b1;
          w.b_im = 1'b1;
          w.acc  = ACC_ADD_RE;
        end
        ST_MUL_IR: begin
          w.mul  = 1'b1;
          w.a_im = 1'b1;
          w.acc  = ACC_SUB_RE;
        end
        ST_MUL_RI: begin
          w.mul  = 1'b1;
          w.b_im = 1'b1;
          w.acc  = ACC_ADD_IM;
        end
        ST_ADD_RI: begin
          w.acc = ACC_ADD_IM;
        end
        ST_WB: begin
          w.wb     = 1'b1;
          w.k_adv  = 1'b1;
          w.cond   = COND_K_MORE;
          w.target = ST_FETCH;
        end
        ST_NEXT: begin
          w.ij_adv = 1'b1;
          w.cond   = COND_IJ_MORE;
          w.target = ST_FETCH;
        end
        ST_EMIT: begin
          w.emit   = 1'b1;
          w.ij_adv = 1'b1;
          w.cond   = COND_IJ_MORE;
          w.target = ST_EMIT;
        end
        ST_DONE: begin
          w.cond   = COND_ALWAYS;
          w.target = ST_IDLE;
        end
        default: begin
          w.cond   = COND_ALWAYS;
          w.target = ST_IDLE;
        end
      endcase
      return w;
    end
  endfunction

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              taken;
  logic              hold;

  assign ctl  = ucode(step_r);
  assign hold = ctl.emit && !stat.out_free;

  always_comb begin
    case (ctl.cond)
      COND_NEXT:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_START: taken = !start;
      COND_K_MORE:   taken = !stat.k_last;
      COND_IJ_MORE:  taken = !stat.ij_last;
      default:       taken = 1'b1;
    endcase
    if (hold) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = ctl.target;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== design/cmma_datapath.sv =====
module cmma_datapath import cmma_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ctl_t                        ctl,
  output stat_t                       stat,
  input  logic                        in_xfer,
  input  logic [1:0]                  in_func,
  input  logic [1:0]                  in_row,
  input  logic [1:0]                  in_col,
  input  logic signed [ELEM_BITS-1:0] in_value_real,
  input  logic signed [ELEM_BITS-1:0] in_value_imag,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [1:0]                  out_row,
  output logic [1:0]                  out_col,
  output logic signed [ELEM_BITS-1:0] out_result_real,
  output logic signed [ELEM_BITS-1:0] out_result_imag,
  output logic                        out_last
);

  cval_t a_mem [DEPTH];
  cval_t b_mem [DEPTH];
  cval_t c_mem [DEPTH];

  cval_t                     a_r;
  cval_t                     b_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_re_r;
  logic signed [ACC_W-1:0]   acc_im_r;
  logic [CNT_W-1:0]          i_r;
  logic [CNT_W-1:0]          j_r;
  logic [CNT_W-1:0]          k_r;
  logic                      out_valid_r;
  logic [1:0]                out_row_r;
  logic [1:0]                out_col_r;
  cval_t                     out_data_r;
  logic                      out_last_r;

  func_t                     func;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_idx;
  logic [IDX_W-1:0]          a_idx;
  logic [IDX_W-1:0]          b_idx;
  logic [IDX_W-1:0]          c_idx;
  logic                      hold;
  logic signed [ELEM_BITS-1:0] op_a;
  logic signed [ELEM_BITS-1:0] op_b;
  logic signed [2*ELEM_BITS-1:0] mul_full;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   c_re_ext;
  logic signed [ACC_W-1:0]   c_im_ext;
  cval_t                     wb_val;
  cval_t                     in_val;

  assign func   = func_t'(in_func);
  assign wr_en  = in_xfer && (func != FUNC_COMPUTE) && (int'(in_row) < DIM)
                  && (int'(in_col) < DIM);
  assign wr_idx = IDX_W'(int'(in_row) * DIM + int'(in_col));
  assign a_idx  = IDX_W'(int'(i_r) * DIM + int'(k_r));
  assign b_idx  = IDX_W'(int'(k_r) * DIM + int'(j_r));
  assign c_idx  = IDX_W'(int'(i_r) * DIM + int'(j_r));
  assign in_val = '{re: in_value_real, im: in_value_imag};

  assign stat.k_last   = (int'(k_r) == DIM - 1);
  assign stat.ij_last  = (int'(i_r) == DIM - 1) && (int'(j_r) == DIM - 1);
  assign stat.out_free = !out_valid_r || !out_stall;
  assign hold          = ctl.emit && !stat.out_free;

  assign op_a     = ctl.a_im ? a_r.im : a_r.re;
  assign op_b     = ctl.b_im ? b_r.im : b_r.re;
  assign mul_full = op_a * op_b;
  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign c_re_ext = {{(ACC_W - ELEM_BITS){c_mem[c_idx].re[ELEM_BITS-1]}}, c_mem[c_idx].re};
  assign c_im_ext = {{(ACC_W - ELEM_BITS){c_mem[c_idx].im[ELEM_BITS-1]}}, c_mem[c_idx].im};
  assign wb_val   = '{re: sat_elem(acc_re_r), im: sat_elem(acc_im_r)};

  always_ff @(posedge clk) begin
    if (wr_en && func == FUNC_WR_A) begin
      a_mem[wr_idx] <= in_val;
    end
    if (wr_en && func == FUNC_WR_B) begin
      b_mem[wr_idx] <= in_val;
    end
    if (ctl.acc == ACC_LOAD) begin
      a_r <= a_mem[a_idx];
      b_r <= b_mem[b_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < DEPTH; n++) begin
        c_mem[n] <= '0;
      end
    end else if (wr_en && func == FUNC_WR_C) begin
      c_mem[wr_idx] <= in_val;
    end else if (ctl.wb) begin
      c_mem[c_idx] <= wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= mul_full[2*ELEM_BITS-1:FRAC_BITS];
    end
    case (ctl.acc)
      ACC_LOAD: begin
        acc_re_r <= c_re_ext;
        acc_im_r <= c_im_ext;
      end
      ACC_ADD_RE: acc_re_r <= acc_re_r + prod_ext;
      ACC_SUB_RE: acc_re_r <= acc_re_r - prod_ext;
      ACC_ADD_IM: acc_im_r <= acc_im_r + prod_ext;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else begin
      if (ctl.k_adv) begin
        k_r <= stat.k_last ? '0 : k_r + CNT_W'(1);
      end
      if (ctl.ij_adv && !hold) begin
        if (int'(j_r) == DIM - 1) begin
          j_r <= '0;
          i_r <= (int'(i_r) == DIM - 1) ? '0 : i_r + CNT_W'(1);
        end else begin
          j_r <= j_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit && !hold) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && !hold) begin
      out_row_r  <= 2'(i_r);
      out_col_r  <= 2'(j_r);
      out_data_r <= c_mem[c_idx];
      out_last_r <= stat.ij_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_result_real = out_data_r.re;
  assign out_result_imag = out_data_r.im;
  assign out_last        = out_last_r;

  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(i_r) < DIM) && (int'(j_r) < DIM) && (int'(k_r) < DIM))
    else $error("matrix counter out of range");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ctl.idle)
    else $error("input transfer while sequencer busy");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && !hold) |=> out_valid_r)
    else $error("emit step did not load output register");

  a_last_at_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |->
      (int'(out_row_r) == DIM - 1) && (int'(out_col_r) == DIM - 1))
    else $error("last flag on wrong entry");

endmodule

// ===== design/complex_matrix_multiply_accumulate.sv =====
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall  | func, row, col, value_real, value_imag
// out_    | output    | out_valid/out_stall| row, col, result_real, result_imag, last
//
// Write items are accepted back to back; in_stall is low only while the sequencer is idle.
// A compute item runs, per C entry and per k, a fetch, the four products of a complex MAC on
// one shared 32x32 multiplier with accumulation, and a write-back; then it emits all of C.
// Emit holds while out_stall blocks the output register.
// rst_n is synchronous: clears the sequencer, counters, out_valid and all of C.
module complex_matrix_multiply_accumulate import cmma_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [1:0]                  in_row,
  input  logic [1:0]                  in_col,
  input  logic signed [ELEM_BITS-1:0] in_value_real,
  input  logic signed [ELEM_BITS-1:0] in_value_imag,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_row,
  output logic [1:0]                  out_col,
  output logic signed [ELEM_BITS-1:0] out_result_real,
  output logic signed [ELEM_BITS-1:0] out_result_imag,
  output logic                        out_last
);

  ctl_t  ctl;
  stat_t stat;
  logic  in_xfer;
  logic  start;

  assign in_stall = !ctl.idle;
  assign in_xfer  = in_valid && !in_stall;
  assign start    = in_xfer && (func_t'(in_func) == FUNC_COMPUTE);

  cmma_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctl   (ctl)
  );

  cmma_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_xfer         (in_xfer),
    .in_func         (in_func),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value_real   (in_value_real),
    .in_value_imag   (in_value_imag),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_result_real (out_result_real),
    .out_result_imag (out_result_imag),
    .out_last        (out_last)
  );

endmodule

// ===== test/cmma_mac_checker.sv =====
module cmma_mac_checker import cmma_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [1:0]                  in_row,
  input  logic [1:0]                  in_col,
  input  logic signed [ELEM_BITS-1:0] in_value_real,
  input  logic signed [ELEM_BITS-1:0] in_value_imag,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [1:0]                  out_row,
  input  logic [1:0]                  out_col,
  input  logic signed [ELEM_BITS-1:0] out_result_real,
  input  logic signed [ELEM_BITS-1:0] out_result_imag,
  input  logic                        out_last,
  output int                          error_count,
  output int                          entries_due
);

  typedef struct {
    logic [1:0]           row;
    logic [1:0]           col;
    logic [ELEM_BITS-1:0] re;
    logic [ELEM_BITS-1:0] im;
    logic                 last;
  } c_entry_t;

  logic signed [ELEM_BITS-1:0] a_re [DEPTH];
  logic signed [ELEM_BITS-1:0] a_im [DEPTH];
  logic signed [ELEM_BITS-1:0] b_re [DEPTH];
  logic signed [ELEM_BITS-1:0] b_im [DEPTH];
  logic signed [ELEM_BITS-1:0] c_re [DEPTH];
  logic signed [ELEM_BITS-1:0] c_im [DEPTH];

  c_entry_t expected_entries[$];
  int       mismatches = 0;

  // exact product, then floor shift by the fraction width
  function automatic longint scaled_mul(input logic signed [ELEM_BITS-1:0] x,
                                        input logic signed [ELEM_BITS-1:0] y);
    longint p;
    p = longint'(x) * longint'(y);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic [ELEM_BITS-1:0] clamp_elem(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (ELEM_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi[ELEM_BITS-1:0];
    end
    if (v < lo) begin
      return lo[ELEM_BITS-1:0];
    end
    return v[ELEM_BITS-1:0];
  endfunction

  always @(posedge clk) begin : track
    int       i, j, k, ci, ai, bi, addr;
    longint   nre, nim;
    c_entry_t e;
    if (!rst_n) begin
      for (i = 0; i < DEPTH; i++) begin
        c_re[i] = '0;
        c_im[i] = '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_COMPUTE) begin
          for (i = 0; i < DIM; i++) begin
            for (j = 0; j < DIM; j++) begin
              ci = i * DIM + j;
              for (k = 0; k < DIM; k++) begin
                ai = i * DIM + k;
                bi = k * DIM + j;
                nre = longint'(c_re[ci]) + scaled_mul(a_re[ai], b_re[bi])
                      - scaled_mul(a_im[ai], b_im[bi]);
                nim = longint'(c_im[ci]) + scaled_mul(a_im[ai], b_re[bi])
                      + scaled_mul(a_re[ai], b_im[bi]);
                c_re[ci] = clamp_elem(nre);
                c_im[ci] = clamp_elem(nim);
              end
              e.row  = i[1:0];
              e.col  = j[1:0];
              e.re   = c_re[ci];
              e.im   = c_im[ci];
              e.last = (i == DIM - 1) && (j == DIM - 1);
              expected_entries.push_back(e);
            end
          end
        end else if (in_row < DIM && in_col < DIM) begin
          addr = in_row * DIM + in_col;
          case (in_func)
            FUNC_WR_A: begin
              a_re[addr] = in_value_real;
              a_im[addr] = in_value_imag;
            end
            FUNC_WR_B: begin
              b_re[addr] = in_value_real;
              b_im[addr] = in_value_imag;
            end
            default: begin
              c_re[addr] = in_value_real;
              c_im[addr] = in_value_imag;
            end
          endcase
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result (%0d,%0d) re %h im %h last %b",
                     out_row, out_col, out_result_real, out_result_imag, out_last);
          end
        end else begin
          e = expected_entries.pop_front();
          if (out_row !== e.row || out_col !== e.col || out_result_real !== e.re ||
              out_result_imag !== e.im || out_last !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected (%0d,%0d) re %h im %h last %b",
                       e.row, e.col, e.re, e.im, e.last);
              $display("          got      (%0d,%0d) re %h im %h last %b",
                       out_row, out_col, out_result_real, out_result_imag, out_last);
            end
          end
        end
      end
    end
    error_count <= mismatches;
    entries_due <= expected_entries.size();
  end

endmodule

// ===== test/tb_complex_matrix_multiply_accumulate.sv =====
module tb_complex_matrix_multiply_accumulate import cmma_pkg::*; ();

  localparam int RAND_ITEMS = 155;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 3000;

  logic                        clk           = 1'b0;
  logic                        rst_n         = 1'b0;
  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic [1:0]                  in_func       = '0;
  logic [1:0]                  in_row        = '0;
  logic [1:0]                  in_col        = '0;
  logic signed [ELEM_BITS-1:0] in_value_real = '0;
  logic signed [ELEM_BITS-1:0] in_value_imag = '0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic [1:0]                  out_row;
  logic [1:0]                  out_col;
  logic signed [ELEM_BITS-1:0] out_result_real;
  logic signed [ELEM_BITS-1:0] out_result_imag;
  logic                        out_last;

  logic no_gaps       = 1'b0;
  logic long_hold_req = 1'b0;
  int   error_count;
  int   entries_due;

  logic [ELEM_BITS-1:0] a_re_init [DEPTH] = '{ELEM_MAX, ELEM_MIN, 32'h0, 32'h0001_0000,
    32'hFFFF_0000, 32'h1, 32'hFFFF_FFFF, 32'h0002_8000, 32'h7FFF_0000};
  logic [ELEM_BITS-1:0] a_im_init [DEPTH] = '{32'h0, ELEM_MAX, ELEM_MIN, 32'h0000_8000,
    32'hFFFF_FFFF, 32'h0003_0000, 32'hFFFE_0000, 32'h0, 32'h8000_0001};
  logic [ELEM_BITS-1:0] b_re_init [DEPTH] = '{ELEM_MAX, ELEM_MAX, 32'h0001_0000,
    32'h0001_0000, 32'h1, ELEM_MIN, 32'hFFFF_8000, 32'h0000_4000, 32'hFFFF_FFFF};
  logic [ELEM_BITS-1:0] b_im_init [DEPTH] = '{ELEM_MIN, 32'h0, 32'h0001_0000,
    32'hFFFF_FFFF, ELEM_MAX, 32'h2, 32'h0, 32'h0005_0000, 32'h7FFF_FFFF};

  complex_matrix_multiply_accumulate uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value_real   (in_value_real),
    .in_value_imag   (in_value_imag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_result_real (out_result_real),
    .out_result_imag (out_result_imag),
    .out_last        (out_last)
  );

  cmma_mac_checker mac_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value_real   (in_value_real),
    .in_value_imag   (in_value_imag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_result_real (out_result_real),
    .out_result_imag (out_result_imag),
    .out_last        (out_last),
    .error_count     (error_count),
    .entries_due     (entries_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return ELEM_MAX;
      1: return ELEM_MIN;
      2: return '0;
      3, 4: return $urandom;
      default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // valid stays high across back-to-back transfers; lowered only ahead of a gap
  task automatic send_item(input logic [1:0] f, input logic [1:0] r, input logic [1:0] c,
                           input logic [ELEM_BITS-1:0] vr, input logic [ELEM_BITS-1:0] vi);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_row        <= r;
    in_col        <= c;
    in_value_real <= vr;
    in_value_imag <= vi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (entries_due != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int wait_left;
    int hold_left;
    bit hold_taken;
    wait_left  = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) begin
          out_stall <= 1'b0;
        end
      end else if (out_valid && !out_stall) begin
        wait_left = no_gaps ? 0 : $urandom_range(0, 8);
        out_stall <= (wait_left > 0);
      end else if (wait_left > 0) begin
        wait_left--;
        if (wait_left == 0) begin
          out_stall <= 1'b0;
        end
      end else if (!no_gaps && $urandom_range(0, 15) == 0) begin
        wait_left = $urandom_range(1, 8);
        out_stall <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int         n;
    int         r;
    logic [1:0] rr;
    logic [1:0] cc;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every A and B entry is written before the first compute
    for (n = 0; n < DEPTH; n++) begin
      send_item(FUNC_WR_A, 2'(n / DIM), 2'(n % DIM), a_re_init[n], a_im_init[n]);
    end
    for (n = 0; n < DEPTH; n++) begin
      send_item(FUNC_WR_B, 2'(n / DIM), 2'(n % DIM), b_re_init[n], b_im_init[n]);
    end
    send_item(FUNC_COMPUTE, 2'd0, 2'd0, '0, '0);
    send_item(FUNC_WR_C, 2'd0, 2'd0, ELEM_MAX, ELEM_MIN);
    send_item(FUNC_WR_C, 2'd2, 2'd2, ELEM_MIN, ELEM_MAX);
    // out-of-range write addresses are dropped; a compute ignores its address
    send_item(FUNC_WR_A, 2'd3, 2'd0, ELEM_MAX, ELEM_MAX);
    send_item(FUNC_WR_B, 2'd1, 2'd3, ELEM_MIN, ELEM_MIN);
    send_item(FUNC_WR_C, 2'd3, 2'd3, 32'h1234_5678, 32'h9ABC_DEF0);
    send_item(FUNC_COMPUTE, 2'd3, 2'd3, ELEM_MAX, ELEM_MIN);

    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 30 == 0) begin
        no_gaps <= ($urandom_range(0, 3) == 0);
      end
      if (n == 120) begin
        drain_results();
      end
      r = $urandom_range(0, 15);
      if (n == 60) begin
        long_hold_req <= 1'b1;
        send_item(FUNC_COMPUTE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  rand_elem(), rand_elem());
      end else if (r < 2) begin
        send_item(FUNC_COMPUTE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  rand_elem(), rand_elem());
      end else if (r == 2) begin
        rr = 2'($urandom_range(0, 3));
        cc = (rr == 2'd3) ? 2'($urandom_range(0, 3)) : 2'd3;
        send_item(2'($urandom_range(0, 2)), rr, cc, rand_elem(), rand_elem());
      end else begin
        send_item(2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)),
                  2'($urandom_range(0, 2)), rand_elem(), rand_elem());
      end
    end
    send_item(FUNC_COMPUTE, 2'd0, 2'd0, '0, '0);

    drain_results();
    repeat (40) @(posedge clk);
    if (error_count == 0 && entries_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cmma_pkg.sv
design/cmma_sequencer.sv
design/cmma_datapath.sv
design/complex_matrix_multiply_accumulate.sv
test/cmma_mac_checker.sv
test/tb_complex_matrix_multiply_accumulate.sv
